// ----- design/rau_pkg.sv -----
// package: widths, codes, payload and control types of the rational arithmetic unit
package rau_pkg;

   // operand width and the widths that follow from it
   localparam int OPERAND_WIDTH = 16;
   localparam int MAG_W         = OPERAND_WIDTH;
   localparam int PROD_W        = 2 * OPERAND_WIDTH;
   localparam int SUM_W         = PROD_W + 1;
   localparam int NUM_OUT_W     = 33;
   localparam int DEN_OUT_W     = 31;
   localparam int GCD_W         = (SUM_W > NUM_OUT_W) ? SUM_W : NUM_OUT_W;
   localparam int K_W           = $clog2(GCD_W + 1);
   localparam int CNT_W         = $clog2(GCD_W);

   typedef logic [MAG_W-1:0]  rau_mag_type;
   typedef logic [PROD_W-1:0] rau_prod_type;
   typedef logic [SUM_W-1:0]  rau_sum_type;
   typedef logic [GCD_W-1:0]  rau_gcd_type;
   typedef logic [GCD_W:0]    rau_trial_type;
   typedef logic [K_W-1:0]    rau_k_type;
   typedef logic [CNT_W-1:0]  rau_cnt_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } rau_op_type;

   // which fraction the shared reduction unit works on
   typedef enum logic [1:0] {
      SEL_A,
      SEL_B,
      SEL_RES
   } rau_sel_type;

   // which cross product the multiplier forms
   typedef enum logic [1:0] {
      MUL_P0,
      MUL_P1,
      MUL_P2
   } rau_mul_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_LOAD,
      ST_GCD,
      ST_DIV_LOAD,
      ST_DIV,
      ST_STORE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_COMBINE
   } rau_state_type;

   typedef struct packed {
      logic [1:0]                req_type;
      logic signed [MAG_W-1:0]   a_num;
      logic signed [MAG_W-1:0]   a_den;
      logic signed [MAG_W-1:0]   b_num;
      logic signed [MAG_W-1:0]   b_den;
   } rau_req_type;

   typedef struct packed {
      logic signed [NUM_OUT_W-1:0] result_num;
      logic [DEN_OUT_W-1:0]        result_den;
      logic                        zero_den_fixed;
   } rau_rsp_type;

   typedef struct packed {
      logic        capture;
      logic        red_load;
      logic        gcd_step;
      logic        div_load;
      logic        div_step;
      logic        red_store;
      logic        mul_en;
      rau_mul_type mul_idx;
      logic        combine;
      rau_sel_type sel;
   } rau_cmd_type;

   typedef struct packed {
      logic gcd_done;
      logic div_last;
      logic out_free;
   } rau_sts_type;

endpackage

// ----- design/rau_controller.sv -----
// controller: sequencing of decode, reductions, cross products and result write
module rau_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rau_pkg::rau_sts_type sts,
   output rau_pkg::rau_cmd_type cmd
);

   rau_pkg::rau_state_type state_ff, state_in;
   rau_pkg::rau_sel_type   sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::ST_IDLE;
         sel_ff   <= rau_pkg::SEL_A;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         rau_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = rau_pkg::ST_RED_LOAD;
               sel_in   = rau_pkg::SEL_A;
            end
         end
         rau_pkg::ST_RED_LOAD: state_in = rau_pkg::ST_GCD;
         rau_pkg::ST_GCD: begin
            if (sts.gcd_done) state_in = rau_pkg::ST_DIV_LOAD;
         end
         rau_pkg::ST_DIV_LOAD: state_in = rau_pkg::ST_DIV;
         rau_pkg::ST_DIV: begin
            if (sts.div_last) state_in = rau_pkg::ST_STORE;
         end
         rau_pkg::ST_STORE: begin
            case (sel_ff)
               rau_pkg::SEL_A: begin
                  sel_in   = rau_pkg::SEL_B;
                  state_in = rau_pkg::ST_RED_LOAD;
               end
               rau_pkg::SEL_B: state_in = rau_pkg::ST_MUL0;
               rau_pkg::SEL_RES: begin
                  if (sts.out_free) state_in = rau_pkg::ST_IDLE;
               end
               default: state_in = rau_pkg::ST_IDLE;
            endcase
         end
         rau_pkg::ST_MUL0: state_in = rau_pkg::ST_MUL1;
         rau_pkg::ST_MUL1: state_in = rau_pkg::ST_MUL2;
         rau_pkg::ST_MUL2: state_in = rau_pkg::ST_COMBINE;
         rau_pkg::ST_COMBINE: begin
            state_in = rau_pkg::ST_RED_LOAD;
            sel_in   = rau_pkg::SEL_RES;
         end
         default: state_in = rau_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      cmd.sel   = sel_ff;
      req_stall = 1'b1;
      case (state_ff)
         rau_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         rau_pkg::ST_RED_LOAD: cmd.red_load = 1'b1;
         rau_pkg::ST_GCD:      cmd.gcd_step = !sts.gcd_done;
         rau_pkg::ST_DIV_LOAD: cmd.div_load = 1'b1;
         rau_pkg::ST_DIV:      cmd.div_step = 1'b1;
         rau_pkg::ST_STORE: begin
            cmd.red_store = (sel_ff != rau_pkg::SEL_RES) || sts.out_free;
         end
         rau_pkg::ST_MUL0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_idx = rau_pkg::MUL_P0;
         end
         rau_pkg::ST_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_idx = rau_pkg::MUL_P1;
         end
         rau_pkg::ST_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_idx = rau_pkg::MUL_P2;
         end
         rau_pkg::ST_COMBINE: cmd.combine = 1'b1;
         default: req_stall = 1'b1;
      endcase
   end

endmodule

// ----- design/rau_datapath.sv -----
// datapath: operand decode, binary gcd, dual restoring divider, multiplier, output register
module rau_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  rau_pkg::rau_req_type req_data,
   input  rau_pkg::rau_cmd_type cmd,
   output rau_pkg::rau_sts_type sts,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rau_pkg::rau_rsp_type rsp_data
);

   // two's complement raw value to sign and magnitude
   function automatic logic [rau_pkg::MAG_W:0] decode(input rau_pkg::rau_mag_type raw);
      rau_pkg::rau_mag_type mag;
      mag = raw[rau_pkg::MAG_W-1] ? (~raw + rau_pkg::rau_mag_type'(1)) : raw;
      return {raw[rau_pkg::MAG_W-1], mag};
   endfunction

   rau_pkg::rau_op_type   op_ff;
   logic                  an_neg_ff, ad_neg_ff, bn_neg_ff, bd_neg_ff;
   rau_pkg::rau_mag_type  an_mag_ff, ad_mag_ff, bn_mag_ff, bd_mag_ff;
   rau_pkg::rau_prod_type p0_ff, p1_ff, p2_ff;
   logic                  rn_neg_ff, rd_neg_ff, fixed_ff;
   rau_pkg::rau_sum_type  rn_mag_ff;
   rau_pkg::rau_prod_type rd_mag_ff;
   logic                  wn_neg_ff, wd_neg_ff;
   rau_pkg::rau_gcd_type  wn_mag_ff, wd_mag_ff;
   rau_pkg::rau_gcd_type  u_ff, v_ff, g_ff;
   rau_pkg::rau_k_type    k_ff;
   rau_pkg::rau_gcd_type  rem_n_ff, rem_d_ff, q_n_ff, q_d_ff;
   rau_pkg::rau_cnt_type  cnt_ff;
   logic                  rsp_valid_ff;
   rau_pkg::rau_rsp_type  rsp_data_ff;

   // reduction source select, zero denominator forced to one
   logic                 src_n_neg, src_d_neg;
   rau_pkg::rau_gcd_type src_n_mag, src_d_mag;

   always_comb begin
      case (cmd.sel)
         rau_pkg::SEL_A: begin
            src_n_neg = an_neg_ff;
            src_n_mag = rau_pkg::rau_gcd_type'(an_mag_ff);
            src_d_neg = ad_neg_ff;
            src_d_mag = rau_pkg::rau_gcd_type'(ad_mag_ff);
         end
         rau_pkg::SEL_B: begin
            src_n_neg = bn_neg_ff;
            src_n_mag = rau_pkg::rau_gcd_type'(bn_mag_ff);
            src_d_neg = bd_neg_ff;
            src_d_mag = rau_pkg::rau_gcd_type'(bd_mag_ff);
         end
         default: begin
            src_n_neg = rn_neg_ff;
            src_n_mag = rau_pkg::rau_gcd_type'(rn_mag_ff);
            src_d_neg = rd_neg_ff;
            src_d_mag = rau_pkg::rau_gcd_type'(rd_mag_ff);
         end
      endcase
      if (src_d_mag == '0) begin
         src_d_mag = rau_pkg::rau_gcd_type'(1);
         src_d_neg = 1'b0;
      end
   end

   // one binary gcd step
   rau_pkg::rau_gcd_type u_in, v_in;
   rau_pkg::rau_k_type   k_in;

   always_comb begin
      u_in = u_ff;
      v_in = v_ff;
      k_in = k_ff;
      if (!u_ff[0] && !v_ff[0]) begin
         u_in = u_ff >> 1;
         v_in = v_ff >> 1;
         k_in = k_ff + rau_pkg::rau_k_type'(1);
      end else if (!u_ff[0]) begin
         u_in = u_ff >> 1;
      end else if (!v_ff[0]) begin
         v_in = v_ff >> 1;
      end else if (u_ff >= v_ff) begin
         u_in = u_ff - v_ff;
      end else begin
         v_in = v_ff - u_ff;
      end
   end

   // restoring division step, numerator and denominator side by side
   rau_pkg::rau_trial_type trial_n, trial_d, diff_n, diff_d;
   logic                   ge_n, ge_d;

   always_comb begin
      trial_n = {rem_n_ff, q_n_ff[rau_pkg::GCD_W-1]};
      trial_d = {rem_d_ff, q_d_ff[rau_pkg::GCD_W-1]};
      diff_n  = trial_n - rau_pkg::rau_trial_type'(g_ff);
      diff_d  = trial_d - rau_pkg::rau_trial_type'(g_ff);
      ge_n    = trial_n >= rau_pkg::rau_trial_type'(g_ff);
      ge_d    = trial_d >= rau_pkg::rau_trial_type'(g_ff);
   end

   // reduced sign and signed numerator for the output
   logic                 red_neg;
   rau_pkg::rau_gcd_type q_n_twos;

   assign red_neg  = (wn_neg_ff != wd_neg_ff) && (q_n_ff != '0);
   assign q_n_twos = red_neg ? (~q_n_ff + rau_pkg::rau_gcd_type'(1)) : q_n_ff;

   // shared multiplier
   rau_pkg::rau_mag_type  mul_x, mul_y;
   rau_pkg::rau_prod_type prod;

   always_comb begin
      case (cmd.mul_idx)
         rau_pkg::MUL_P0: begin
            mul_x = an_mag_ff;
            mul_y = (op_ff == rau_pkg::OP_MUL) ? bn_mag_ff : bd_mag_ff;
         end
         rau_pkg::MUL_P1: begin
            mul_x = bn_mag_ff;
            mul_y = ad_mag_ff;
         end
         default: begin
            mul_x = ad_mag_ff;
            mul_y = bd_mag_ff;
         end
      endcase
      prod = rau_pkg::rau_prod_type'(mul_x) * rau_pkg::rau_prod_type'(mul_y);
   end

   // combine the cross products into the raw result
   logic                  x_neg, y_neg, sm_neg;
   rau_pkg::rau_sum_type  xm, ym, sm_mag;
   logic                  cmb_n_neg, cmb_d_neg;
   rau_pkg::rau_sum_type  cmb_n_mag;
   rau_pkg::rau_prod_type cmb_d_mag;

   always_comb begin
      x_neg = an_neg_ff;
      y_neg = (op_ff == rau_pkg::OP_SUB) ? !bn_neg_ff : bn_neg_ff;
      xm    = rau_pkg::rau_sum_type'(p0_ff);
      ym    = rau_pkg::rau_sum_type'(p1_ff);
      if (x_neg == y_neg) begin
         sm_mag = xm + ym;
         sm_neg = x_neg;
      end else if (xm >= ym) begin
         sm_mag = xm - ym;
         sm_neg = x_neg;
      end else begin
         sm_mag = ym - xm;
         sm_neg = y_neg;
      end
      case (op_ff)
         rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
            cmb_n_neg = sm_neg;
            cmb_n_mag = sm_mag;
            cmb_d_neg = 1'b0;
            cmb_d_mag = p2_ff;
         end
         rau_pkg::OP_MUL: begin
            cmb_n_neg = an_neg_ff ^ bn_neg_ff;
            cmb_n_mag = xm;
            cmb_d_neg = 1'b0;
            cmb_d_mag = p2_ff;
         end
         default: begin
            cmb_n_neg = an_neg_ff;
            cmb_n_mag = xm;
            cmb_d_neg = bn_neg_ff;
            cmb_d_mag = p1_ff;
         end
      endcase
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff                  <= rau_pkg::rau_op_type'(req_data.req_type);
         {an_neg_ff, an_mag_ff} <= decode(req_data.a_num);
         {ad_neg_ff, ad_mag_ff} <= decode(req_data.a_den);
         {bn_neg_ff, bn_mag_ff} <= decode(req_data.b_num);
         {bd_neg_ff, bd_mag_ff} <= decode(req_data.b_den);
      end
      if (cmd.red_load) begin
         wn_neg_ff <= src_n_neg;
         wn_mag_ff <= src_n_mag;
         wd_neg_ff <= src_d_neg;
         wd_mag_ff <= src_d_mag;
         u_ff      <= src_n_mag;
         v_ff      <= src_d_mag;
         k_ff      <= '0;
      end
      if (cmd.gcd_step) begin
         u_ff <= u_in;
         v_ff <= v_in;
         k_ff <= k_in;
      end
      if (cmd.div_load) begin
         g_ff     <= v_ff << k_ff;
         q_n_ff   <= wn_mag_ff;
         q_d_ff   <= wd_mag_ff;
         rem_n_ff <= '0;
         rem_d_ff <= '0;
         cnt_ff   <= '0;
      end
      if (cmd.div_step) begin
         rem_n_ff <= rau_pkg::rau_gcd_type'(ge_n ? diff_n : trial_n);
         rem_d_ff <= rau_pkg::rau_gcd_type'(ge_d ? diff_d : trial_d);
         q_n_ff   <= {q_n_ff[rau_pkg::GCD_W-2:0], ge_n};
         q_d_ff   <= {q_d_ff[rau_pkg::GCD_W-2:0], ge_d};
         cnt_ff   <= cnt_ff + rau_pkg::rau_cnt_type'(1);
      end
      if (cmd.red_store) begin
         case (cmd.sel)
            rau_pkg::SEL_A: begin
               an_neg_ff <= red_neg;
               an_mag_ff <= rau_pkg::rau_mag_type'(q_n_ff);
               ad_neg_ff <= 1'b0;
               ad_mag_ff <= rau_pkg::rau_mag_type'(q_d_ff);
            end
            rau_pkg::SEL_B: begin
               bn_neg_ff <= red_neg;
               bn_mag_ff <= rau_pkg::rau_mag_type'(q_n_ff);
               bd_neg_ff <= 1'b0;
               bd_mag_ff <= rau_pkg::rau_mag_type'(q_d_ff);
            end
            default: begin
               rsp_data_ff.result_num     <= q_n_twos[rau_pkg::NUM_OUT_W-1:0];
               rsp_data_ff.result_den     <= q_d_ff[rau_pkg::DEN_OUT_W-1:0];
               rsp_data_ff.zero_den_fixed <= fixed_ff;
            end
         endcase
      end
      if (cmd.mul_en) begin
         case (cmd.mul_idx)
            rau_pkg::MUL_P0: p0_ff <= prod;
            rau_pkg::MUL_P1: p1_ff <= prod;
            default:         p2_ff <= prod;
         endcase
      end
      if (cmd.combine) begin
         rn_neg_ff <= cmb_n_neg;
         rn_mag_ff <= cmb_n_mag;
         rd_neg_ff <= cmb_d_neg;
         rd_mag_ff <= cmb_d_mag;
         fixed_ff  <= (cmb_d_mag == '0);
      end
   end

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.red_store && (cmd.sel == rau_pkg::SEL_RES)) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.gcd_done = (u_ff == '0);
   assign sts.div_last = (cnt_ff == rau_pkg::rau_cnt_type'(rau_pkg::GCD_W - 1));
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/rational_arithmetic_unit_core.sv -----
// top level of the rational arithmetic unit: controller and datapath
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  rau_req_type: opcode, a_num, a_den, b_num, b_den
//   rsp_      out        rsp_valid / rsp_stall  rau_rsp_type: result_num, result_den, flag
//
// one request at a time; a request runs through three reductions (operand a, operand b,
// result), each a load, the binary gcd steps, a divider load, the divide steps and a
// store, with three cross products and a combine between the second and third reductions
// reset is synchronous and clears only the state machine and the output valid
// a held result sits in the output register; the next request is taken and worked on
// meanwhile, and only its final write waits for the output register to drain
module rational_arithmetic_unit_core (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rau_pkg::rau_req_type req_data,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rau_pkg::rau_rsp_type rsp_data
);

   // command and status between sequencer and datapath
   rau_pkg::rau_cmd_type cmd;
   rau_pkg::rau_sts_type sts;

   // sequencer: decode, reduce a, reduce b, cross products, reduce result, write back
   rau_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: shared gcd and divider, one multiplier, output register
   rau_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- design/rau_checker.sv -----
// checker: port level properties of the rational arithmetic unit, bound to the top level
module rau_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input rau_pkg::rau_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rau_pkg::rau_rsp_type rsp_data
);

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // nothing leaves straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // a request keeps the unit busy on the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      !reset && req_valid && !req_stall |=> req_stall)
      else $error("request taken back to back");

   // forced denominator is one, and a zero result is 0/1
   a_den_fix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.zero_den_fixed || rsp_data.result_num == '0)
         |-> rsp_data.result_den == rau_pkg::DEN_OUT_W'(1))
      else $error("bad result denominator");

   // denominator never zero
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.result_den != '0)
      else $error("zero result denominator");

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (.*);
